FILE: hdl/hdtu_pkg.sv
// Package for the HTTP date to Unix time block: types, codes and date helpers.
// Used by the parser, queue, converter and top level under hdl; depends on nothing.
package hdtu_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned SecW = 32;
  localparam int unsigned FifoDepth = 4;

  localparam logic [31:0] KeyDate = 32'h44415445;

  // Parsed date fields handed from the parser to the converter.
  typedef struct packed {
    logic        valid_syntax;
    logic [2:0]  weekday;
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Returns {not_found, index}.
  function automatic logic [3:0] find_weekday(input logic [23:0] k);
    logic [3:0] r;
    r = 4'h8;
    case (k)
      24'h53554E: r = 4'h0;
      24'h4D4F4E: r = 4'h1;
      24'h545545: r = 4'h2;
      24'h574544: r = 4'h3;
      24'h544855: r = 4'h4;
      24'h465249: r = 4'h5;
      24'h534154: r = 4'h6;
      default:    r = 4'h8;
    endcase
    return r;
  endfunction

  // Returns month 1..12, or 0 when not found.
  function automatic logic [3:0] find_month(input logic [23:0] k);
    logic [3:0] r;
    case (k)
      24'h4A414E: r = 4'd1;
      24'h464542: r = 4'd2;
      24'h4D4152: r = 4'd3;
      24'h415052: r = 4'd4;
      24'h4D4159: r = 4'd5;
      24'h4A554E: r = 4'd6;
      24'h4A554C: r = 4'd7;
      24'h415547: r = 4'd8;
      24'h534550: r = 4'd9;
      24'h4F4354: r = 4'd10;
      24'h4E4F56: r = 4'd11;
      24'h444543: r = 4'd12;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  // Days before the month in a non-leap year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'd0;     4'd2: r = 9'd31;    4'd3: r = 9'd59;
      4'd4: r = 9'd90;    4'd5: r = 9'd120;   4'd6: r = 9'd151;
      4'd7: r = 9'd181;   4'd8: r = 9'd212;   4'd9: r = 9'd243;
      4'd10: r = 9'd273;  4'd11: r = 9'd304;  4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2: r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hdtu_parser.sv
// Front end: character scanner that classifies each byte and collects date fields.
// Depends on hdtu_pkg.
module hdtu_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output logic                done_o,
  output hdtu_pkg::fields_t   fields_o
);
  import hdtu_pkg::*;

  typedef enum logic [2:0] {
    PhLead, PhPrefix, PhTail, PhColon, PhBody, PhTrail
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] pfx_q, pfx_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  wd_q, wd_d;
  logic [6:0]  day_q, day_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;
  logic [3:0]  mo_q, mo_d;
  logic [13:0] yr_q, yr_d;
  logic        fail_q, fail_d;

  logic [7:0]  c, uc;
  logic [3:0]  dg, wk, mn, wk_pfx;
  logic [31:0] pfx_push;
  phase_e      ph;
  logic        good;

  always_comb begin
    c = char_i;
    uc = upcase(c);
    dg = c[3:0];
    pfx_push = {pfx_q[23:0], uc};
    wk = find_weekday(pfx_push[23:0]);
    mn = find_month(pfx_push[23:0]);
    wk_pfx = find_weekday(pfx_q[23:0]);
    phase_d = phase_q; pos_d = pos_q; pfx_d = pfx_q; cnt_d = cnt_q;
    wd_d = wd_q; day_d = day_q; mo_d = mo_q; yr_d = yr_q;
    hr_d = hr_q; mi_d = mi_q; se_d = se_q; fail_d = fail_q;
    ph = phase_q;
    good = 1'b1;
    if (!fail_q) begin
      if (ph == PhLead && !is_ws(c)) ph = PhPrefix;
      if (ph == PhColon && !is_ws(c)) begin
        ph = PhBody;
        pos_d = 5'd0;
      end
      phase_d = ph;
      case (ph)
        PhLead, PhColon: ;
        PhPrefix, PhTail: begin
          if (c == 8'h3A) begin
            if (cnt_q == 3'd4 && pfx_q == KeyDate) begin
              phase_d = PhColon;
              pfx_d = '0;
            end else fail_d = 1'b1;
          end else if (c == 8'h2C) begin
            if (ph == PhPrefix && cnt_q == 3'd3 && !wk_pfx[3]) begin
              wd_d = wk_pfx[2:0];
              pos_d = 5'd4;
              phase_d = PhBody;
            end else fail_d = 1'b1;
          end else if (is_ws(c)) begin
            phase_d = PhTail;
          end else if (ph == PhPrefix && cnt_q < 3'd4) begin
            pfx_d = pfx_push;
            cnt_d = cnt_q + 3'd1;
          end else fail_d = 1'b1;
        end
        PhBody: begin
          case (pos_d)
            5'd0, 5'd1, 5'd8, 5'd9: pfx_d = pfx_push;
            5'd2: begin
              pfx_d = pfx_push;
              good = !wk[3];
              wd_d = wk[2:0];
            end
            5'd10: begin
              pfx_d = pfx_push;
              good = mn != 4'd0;
              mo_d = mn;
            end
            5'd3: good = c == 8'h2C;
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25: good = c == 8'h20;
            5'd19, 5'd22: good = c == 8'h3A;
            5'd5, 5'd6: begin
              good = is_digit(c);
              day_d = 7'(day_q * 7'd10 + 7'(dg));
            end
            5'd12, 5'd13, 5'd14, 5'd15: begin
              good = is_digit(c);
              yr_d = 14'(yr_q * 14'd10 + 14'(dg));
            end
            5'd17, 5'd18: begin
              good = is_digit(c);
              hr_d = 7'(hr_q * 7'd10 + 7'(dg));
            end
            5'd20, 5'd21: begin
              good = is_digit(c);
              mi_d = 7'(mi_q * 7'd10 + 7'(dg));
            end
            5'd23, 5'd24: begin
              good = is_digit(c);
              se_d = 7'(se_q * 7'd10 + 7'(dg));
            end
            5'd26: good = uc == 8'h47;
            5'd27: good = uc == 8'h4D;
            5'd28: good = uc == 8'h54;
            default: good = 1'b0;
          endcase
          if (!good) fail_d = 1'b1;
          else if (pos_d >= 5'd28) phase_d = PhTrail;
          else pos_d = pos_d + 5'd1;
        end
        PhTrail: if (!is_ws(c)) fail_d = 1'b1;
        default: fail_d = 1'b1;
      endcase
    end
    fields_o.valid_syntax = !fail_d && phase_d == PhTrail;
    fields_o.weekday = wd_d;
    fields_o.day = day_d;
    fields_o.month = mo_d;
    fields_o.year = yr_d;
    fields_o.hour = hr_d;
    fields_o.minute = mi_d;
    fields_o.second = se_d;
    done_o = valid_i && last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead; pos_q <= '0; pfx_q <= '0; cnt_q <= '0; wd_q <= '0;
      day_q <= '0; mo_q <= '0; yr_q <= '0; hr_q <= '0; mi_q <= '0; se_q <= '0;
      fail_q <= 1'b0;
    end else if (valid_i) begin
      if (last_i) begin
        phase_q <= PhLead; pos_q <= '0; pfx_q <= '0; cnt_q <= '0; wd_q <= '0;
        day_q <= '0; mo_q <= '0; yr_q <= '0; hr_q <= '0; mi_q <= '0;
        se_q <= '0; fail_q <= 1'b0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; pfx_q <= pfx_d; cnt_q <= cnt_d;
        wd_q <= wd_d; day_q <= day_d; mo_q <= mo_d; yr_q <= yr_d;
        hr_q <= hr_d; mi_q <= mi_d; se_q <= se_d; fail_q <= fail_d;
      end
    end
  end

endmodule

FILE: hdl/hdtu_fifo.sv
// Short queue of parsed date records between parser and converter.
// Depends on hdtu_pkg.
module hdtu_fifo #(
  parameter int unsigned Depth = hdtu_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hdtu_pkg::fields_t data_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output hdtu_pkg::fields_t data_o
);
  import hdtu_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  fields_t            mem_q [Depth];
  logic [AW-1:0]      wr_q, rd_q;
  logic [AW:0]        cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o)
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i && !empty_o)
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

endmodule

FILE: hdl/hdtu_convert.sv
// Back end: checks the parsed date and converts it to Unix seconds in a pipeline.
// Depends on hdtu_pkg.
module hdtu_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hdtu_pkg::fields_t fields_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              ok_o,
  output logic [31:0]       secs_o
);
  import hdtu_pkg::*;

  // Stage 1: validity, day count from year 1970 via leap counts, and seconds of the day.
  // Stage 2: weekday check.
  // Stage 3: days * 86400 + seconds with range check.
  logic        v1_q, v2_q, v3_q;
  logic        ok1_q, ok2_q, ok3_q;
  logic [21:0] days1_q;
  logic [16:0] tod1_q;
  logic [2:0]  wd1_q;
  logic [21:0] days2_q;
  logic [16:0] tod2_q;
  logic [31:0] sec3_q;
  logic        adv1, adv2, adv3;

  logic [13:0] y, y1;
  logic [26:0] yc_prod, y1c_prod;
  logic [7:0]  yc, q100;
  logic        cent;
  logic        leap;
  logic [4:0]  dim;
  logic        ok1;
  logic [21:0] days1;
  logic [11:0] q4;
  logic [5:0]  q400;
  logic [16:0] tod1;
  logic [22:0] dx;
  logic [46:0] dq_prod;
  logic [20:0] dq;
  logic [2:0]  dow;
  logic [47:0] total;

  assign adv3 = !v3_q || ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    y = fields_i.year;
    y1 = y - 14'd1;
    // Divide by 100 as a reciprocal multiply, exact for 14-bit years.
    yc_prod = 27'(y) * 27'd5243;
    yc = yc_prod[26:19];
    cent = y == 14'(14'(yc) * 14'd100);
    leap = (y[1:0] == 2'b00 && !cent) || (cent && yc[1:0] == 2'b00);
    dim = (fields_i.month == 4'd2 && leap) ? 5'd29 : month_len(fields_i.month);
    ok1 = fields_i.valid_syntax && fields_i.month >= 4'd1 && fields_i.month <= 4'd12 &&
          fields_i.day >= 7'd1 && fields_i.day <= 7'(dim) &&
          fields_i.hour <= 7'd23 && fields_i.minute <= 7'd59 &&
          fields_i.second <= 7'd59 && y >= 14'd1970;
    y1c_prod = 27'(y1) * 27'd5243;
    q100 = y1c_prod[26:19];
    q4 = y1[13:2];
    q400 = q100[7:2];
    days1 = 22'(22'(y1) * 22'd365 + 22'(q4) - 22'(q100) + 22'(q400)
            - 22'd719162 + 22'(days_before(fields_i.month))
            + 22'((fields_i.month > 4'd2 && leap) ? 1 : 0) + 22'(fields_i.day) - 22'd1);
    tod1 = 17'(17'(fields_i.hour) * 17'd3600 + 17'(fields_i.minute) * 17'd60
           + 17'(fields_i.second));
    // Modulo 7 as a reciprocal multiply, exact below 2^23.
    dx = 23'(days1_q) + 23'd4;
    dq_prod = 47'(dx) * 47'd9586981;
    dq = dq_prod[46:26];
    dow = 3'(dx - 23'(dq) * 23'd7);
    total = 48'(days2_q) * 48'd86400 + 48'(tod2_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      days1_q <= days1; tod1_q <= tod1; wd1_q <= fields_i.weekday;
    end
    if (adv2) begin
      days2_q <= days1_q; tod2_q <= tod1_q;
    end
    if (adv3) sec3_q <= (ok2_q && total <= 48'hFFFF_FFFF) ? total[31:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      ok1_q <= 1'b0; ok2_q <= 1'b0; ok3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= valid_i; ok1_q <= ok1;
      end
      if (adv2) begin
        v2_q <= v1_q; ok2_q <= ok1_q && dow == wd1_q;
      end
      if (adv3) begin
        v3_q <= v2_q; ok3_q <= ok2_q && total <= 48'hFFFF_FFFF;
      end
    end
  end

  assign valid_o = v3_q;
  assign ok_o    = ok3_q;
  assign secs_o  = sec3_q;

endmodule

FILE: hdl/http_date_to_unix_time.sv
// Top level: HTTP IMF-fixdate text stream to Unix seconds.
// Each parsed date is written into the queue, then passes the converter's check, weekday and seconds stages.
// Throughput: one character per cycle; the parser stalls only when its queue is full.
// Reset (async, active low) clears parser state, queue pointers and pipeline valids.
// Depends on hdtu_pkg, hdtu_parser, hdtu_fifo, hdtu_convert.
module http_date_to_unix_time #(
  parameter int unsigned FifoDepth = hdtu_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_char
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // ok, unix_seconds[32:1], zero pad
);
  import hdtu_pkg::*;

  logic    acc, done, full, empty, cv_ready, ok;
  fields_t pf, qf;
  logic [31:0] secs;

  assign s_axis_tready = !full;
  assign acc = s_axis_tvalid && s_axis_tready;

  hdtu_parser u_parser (
    .clk_i, .rst_ni, .valid_i(acc), .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .done_o(done), .fields_o(pf)
  );

  hdtu_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(done), .data_i(pf), .full_o(full), .empty_o(empty),
    .pop_i(cv_ready), .data_o(qf)
  );

  hdtu_convert u_conv (
    .clk_i, .rst_ni, .valid_i(!empty), .ready_o(cv_ready), .fields_i(qf),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .ok_o(ok), .secs_o(secs)
  );

  assign m_axis_tdata = {7'b0, secs, ok};

endmodule

FILE: hdl/hdtu_checker.sv
// Port-level checker for http_date_to_unix_time, bound to the top level.
// Depends on nothing but the top level's ports.
module hdtu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_zero_when_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '0)
    else $error("nonzero seconds on rejected date");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:33] == '0)
    else $error("pad bits set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_no_out_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind http_date_to_unix_time hdtu_checker u_chk (.*);
